/* sv/stc_pkg.sv */
// Shared types and constants for the strided tensor copy address generator.
// Used by every module of the block and by its checker.
package stc_pkg;

   localparam int ADDR_W      = 64;
   localparam int STRIDE_W    = 32;
   localparam int NUM_DIMS    = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int ESZ_W       = 3;
   localparam int QUEUE_DEPTH = 4;

   // size check pipeline is four deep; requests held off until it has settled
   localparam int SETTLE_CYCLES = 5;
   localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_DIMS       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_STRIDES_LO = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_STRIDES_HI = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_DIMS       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_STRIDES_LO = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_STRIDES_HI = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEM_SIZE_LOG2 = 3'd6;

   localparam logic [CSR_DATA_W-1:0] DIMS_RESET = 64'h0001_0001_0001_0001;

   typedef struct packed {
      logic [ADDR_W-1:0] src_base;
      logic [ADDR_W-1:0] dst_base;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] src_address;
      logic [ADDR_W-1:0] dst_address;
      logic              last;
      logic              size_mismatch;
   } rsp_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] src_shape;
      logic [CSR_DATA_W-1:0] src_strides_lo;
      logic [CSR_DATA_W-1:0] src_strides_hi;
      logic [CSR_DATA_W-1:0] dst_shape;
      logic [CSR_DATA_W-1:0] dst_strides_lo;
      logic [CSR_DATA_W-1:0] dst_strides_hi;
      logic [ESZ_W-1:0]      elem_size_log2;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // stride of dimension sel out of a low/high register pair
   function automatic logic [STRIDE_W-1:0] stride_field(input logic [CSR_DATA_W-1:0] lo,
                                                        input logic [CSR_DATA_W-1:0] hi,
                                                        input logic [1:0]            sel);
      logic [CSR_DATA_W-1:0] w;
      w = sel[1] ? hi : lo;
      return sel[0] ? w[63:32] : w[31:0];
   endfunction

endpackage

/* sv/strided_tensor_copy_addr_gen.sv */
// Four-dimensional strided copy address generator.
//
// Each request (req_valid/req_ready, req_data = source and destination base)
// asks for the next element of a copy. One response per request on
// rsp_valid/rsp_ready: source and destination byte addresses, base plus the
// index/stride dot product shifted by log2 of the element size, a last flag
// on the final source element (both index counters then restart at zero),
// and a size mismatch flag when element totals differ or a dimension is zero.
// Configuration registers are written through csr_we/csr_index/csr_wdata.
//
// Path: a request's queue entry is written at the accepting edge, then the
// multiply, pair sum, offset sum and base add registers follow in that order,
// the last of them holding the response.
// Throughput: one request per cycle while req_ready is high, set by the combinational
// index counter advance in the front end and the fully pipelined address unit.
// When the receiver stalls, the address pipeline freezes and the 4-entry queue
// absorbs requests until full, then req_ready drops.
// Reset clears the index counters and loads the register reset values;
// req_ready stays low after reset and after any register write while the
// element-total pipeline settles.
module strided_tensor_copy_addr_gen import stc_pkg::*; #(
   parameter int DIM_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ENTRY_W = 2 * ADDR_W + 2 * NUM_DIMS * DIM_BITS + 2;
   localparam int EXT_W   = CSR_DATA_W + NUM_DIMS * DIM_BITS;

   cfg_type             cfg_ff;
   cfg_type             cfg_in;
   logic [EXT_W-1:0]    src_shape_ext;
   logic [EXT_W-1:0]    dst_shape_ext;
   logic [DIM_BITS-1:0] src_dim [NUM_DIMS];
   logic [DIM_BITS-1:0] dst_dim [NUM_DIMS];
   logic                mismatch;
   logic                push;
   logic                pop;
   logic [ENTRY_W-1:0]  push_data;
   logic [ENTRY_W-1:0]  pop_data;
   queue_status_type    q_status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SRC_DIMS:       cfg_in.src_shape      = csr_wdata;
            CSR_SRC_STRIDES_LO: cfg_in.src_strides_lo = csr_wdata;
            CSR_SRC_STRIDES_HI: cfg_in.src_strides_hi = csr_wdata;
            CSR_DST_DIMS:       cfg_in.dst_shape      = csr_wdata;
            CSR_DST_STRIDES_LO: cfg_in.dst_strides_lo = csr_wdata;
            CSR_DST_STRIDES_HI: cfg_in.dst_strides_hi = csr_wdata;
            CSR_ELEM_SIZE_LOG2: cfg_in.elem_size_log2 = csr_wdata[ESZ_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_shape      <= DIMS_RESET;
         cfg_ff.src_strides_lo <= '0;
         cfg_ff.src_strides_hi <= '0;
         cfg_ff.dst_shape      <= DIMS_RESET;
         cfg_ff.dst_strides_lo <= '0;
         cfg_ff.dst_strides_hi <= '0;
         cfg_ff.elem_size_log2 <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // dimension fields past bit 63 read as zero
   assign src_shape_ext = {{(NUM_DIMS * DIM_BITS){1'b0}}, cfg_ff.src_shape};
   assign dst_shape_ext = {{(NUM_DIMS * DIM_BITS){1'b0}}, cfg_ff.dst_shape};

   for (genvar i = 0; i < NUM_DIMS; i++) begin : g_dim
      assign src_dim[i] = src_shape_ext[i * DIM_BITS +: DIM_BITS];
      assign dst_dim[i] = dst_shape_ext[i * DIM_BITS +: DIM_BITS];
   end

   stc_size_check #(
      .DIM_BITS (DIM_BITS)
   ) u_size_check (
      .clock    (clock),
      .src_dim  (src_dim),
      .dst_dim  (dst_dim),
      .mismatch (mismatch)
   );

   stc_front #(
      .DIM_BITS (DIM_BITS),
      .ENTRY_W  (ENTRY_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .src_dim   (src_dim),
      .dst_dim   (dst_dim),
      .mismatch  (mismatch),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   stc_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   stc_back #(
      .DIM_BITS (DIM_BITS),
      .ENTRY_W  (ENTRY_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .q_data    (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* sv/stc_size_check.sv */
// Element total comparison for the source and destination shapes.
// Four-stage registered pipeline from the dimension fields; depends on stc_pkg.
module stc_size_check import stc_pkg::*; #(
   parameter int DIM_BITS = 16
) (
   input  logic                clock,
   input  logic [DIM_BITS-1:0] src_dim [NUM_DIMS],
   input  logic [DIM_BITS-1:0] dst_dim [NUM_DIMS],
   output logic                mismatch
);

   localparam int PAIR_W = 2 * DIM_BITS;

   logic [DIM_BITS-1:0] dim [2][NUM_DIMS];

   // stage 1: pair products, zero flag
   logic [PAIR_W-1:0] p01_ff [2];
   logic [PAIR_W-1:0] p23_ff [2];
   logic              zero1_ff;
   // stage 2: 32x32 partial products of the 64-bit total
   logic [63:0]       ll_ff [2];
   logic [31:0]       lh_ff [2];
   logic [31:0]       hl_ff [2];
   logic              zero2_ff;
   // stage 3: totals modulo 2^64
   logic [63:0]       tot_ff [2];
   logic              zero3_ff;
   logic              mismatch_ff;
   logic              zero_in;

   always_comb begin
      for (int i = 0; i < NUM_DIMS; i++) begin
         dim[0][i] = src_dim[i];
         dim[1][i] = dst_dim[i];
      end
      zero_in = 1'b0;
      for (int i = 0; i < NUM_DIMS; i++) begin
         if (src_dim[i] == '0 || dst_dim[i] == '0) begin
            zero_in = 1'b1;
         end
      end
   end

   for (genvar s = 0; s < 2; s++) begin : g_side
      logic [63:0] a;
      logic [63:0] b;
      assign a = 64'(p01_ff[s]);
      assign b = 64'(p23_ff[s]);

      always_ff @(posedge clock) begin
         p01_ff[s] <= dim[s][0] * dim[s][1];
         p23_ff[s] <= dim[s][2] * dim[s][3];
         ll_ff[s]  <= a[31:0] * b[31:0];
         lh_ff[s]  <= 32'(a[31:0] * b[63:32]);
         hl_ff[s]  <= 32'(a[63:32] * b[31:0]);
         tot_ff[s] <= ll_ff[s] + {lh_ff[s] + hl_ff[s], 32'h0};
      end
   end

   always_ff @(posedge clock) begin
      zero1_ff    <= zero_in;
      zero2_ff    <= zero1_ff;
      zero3_ff    <= zero2_ff;
      mismatch_ff <= zero3_ff || (tot_ff[0] != tot_ff[1]);
   end

   assign mismatch = mismatch_ff;

endmodule

/* sv/stc_front.sv */
// Front end: request acceptance, source/destination index counters and last flag.
// Pushes one queue entry per request; depends on stc_pkg.
module stc_front import stc_pkg::*; #(
   parameter int DIM_BITS = 16,
   parameter int ENTRY_W  = 2 * ADDR_W + 2 * NUM_DIMS * DIM_BITS + 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   input  logic [DIM_BITS-1:0] src_dim [NUM_DIMS],
   input  logic [DIM_BITS-1:0] dst_dim [NUM_DIMS],
   input  logic                mismatch,
   input  queue_status_type    q_status,
   output logic                push,
   output logic [ENTRY_W-1:0]  push_data
);

   localparam int IDX_BASE = 2;

   logic [DIM_BITS-1:0] src_idx_ff [NUM_DIMS];
   logic [DIM_BITS-1:0] src_idx_in [NUM_DIMS];
   logic [DIM_BITS-1:0] dst_idx_ff [NUM_DIMS];
   logic [DIM_BITS-1:0] dst_idx_in [NUM_DIMS];
   logic [SETTLE_W-1:0] settle_ff;
   logic [SETTLE_W-1:0] settle_in;
   logic [DIM_BITS:0]   s_nxt [NUM_DIMS];
   logic [DIM_BITS:0]   d_nxt [NUM_DIMS];
   logic                last;

   assign req_ready = (settle_ff == '0) && !q_status.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      settle_in = settle_ff;
      if (csr_we) begin
         settle_in = SETTLE_W'(SETTLE_CYCLES);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end
   end

   // ripple advance, dimension 0 fastest; an index at or past its size wraps
   always_comb begin
      for (int i = 0; i < NUM_DIMS; i++) begin
         s_nxt[i] = {1'b0, src_idx_ff[i]};
         d_nxt[i] = {1'b0, dst_idx_ff[i]};
      end
      s_nxt[0] = s_nxt[0] + 1'b1;
      d_nxt[0] = d_nxt[0] + 1'b1;
      for (int i = 0; i < NUM_DIMS - 1; i++) begin
         if (s_nxt[i] >= {1'b0, src_dim[i]}) begin
            s_nxt[i]     = '0;
            s_nxt[i + 1] = s_nxt[i + 1] + 1'b1;
         end
         if (d_nxt[i] >= {1'b0, dst_dim[i]}) begin
            d_nxt[i]     = '0;
            d_nxt[i + 1] = d_nxt[i + 1] + 1'b1;
         end
      end
      last = (s_nxt[NUM_DIMS-1] >= {1'b0, src_dim[NUM_DIMS-1]});
      for (int i = 0; i < NUM_DIMS; i++) begin
         src_idx_in[i] = src_idx_ff[i];
         dst_idx_in[i] = dst_idx_ff[i];
         if (push) begin
            src_idx_in[i] = last ? '0 : s_nxt[i][DIM_BITS-1:0];
            dst_idx_in[i] = last ? '0 : d_nxt[i][DIM_BITS-1:0];
         end
      end
   end

   // entry: src_base, dst_base, src indices, dst indices, last, mismatch
   always_comb begin
      push_data = '0;
      push_data[1] = last;
      push_data[0] = mismatch;
      for (int i = 0; i < NUM_DIMS; i++) begin
         push_data[IDX_BASE + i * DIM_BITS +: DIM_BITS] = dst_idx_ff[i];
         push_data[IDX_BASE + (NUM_DIMS + i) * DIM_BITS +: DIM_BITS] = src_idx_ff[i];
      end
      push_data[IDX_BASE + 2 * NUM_DIMS * DIM_BITS +: ADDR_W] = req_data.dst_base;
      push_data[IDX_BASE + 2 * NUM_DIMS * DIM_BITS + ADDR_W +: ADDR_W] = req_data.src_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_W'(SETTLE_CYCLES);
         for (int i = 0; i < NUM_DIMS; i++) begin
            src_idx_ff[i] <= '0;
            dst_idx_ff[i] <= '0;
         end
      end else begin
         settle_ff <= settle_in;
         for (int i = 0; i < NUM_DIMS; i++) begin
            src_idx_ff[i] <= src_idx_in[i];
            dst_idx_ff[i] <= dst_idx_in[i];
         end
      end
   end

endmodule

/* sv/stc_queue.sv */
// Small FIFO between the front end and the address pipeline.
// Register array with one read pointer; depends on stc_pkg.
module stc_queue import stc_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* sv/stc_back.sv */
// Back end: address pipeline (multiply, pair sums, offset, base add) and output register.
// Takes entries from stc_queue; depends on stc_pkg.
module stc_back import stc_pkg::*; #(
   parameter int DIM_BITS = 16,
   parameter int ENTRY_W  = 2 * ADDR_W + 2 * NUM_DIMS * DIM_BITS + 2
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  queue_status_type   q_status,
   input  logic [ENTRY_W-1:0] q_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data
);

   localparam int IDX_BASE = 2;
   localparam int PROD_W   = DIM_BITS + STRIDE_W;

   logic                en;
   logic [DIM_BITS-1:0] s_idx [NUM_DIMS];
   logic [DIM_BITS-1:0] d_idx [NUM_DIMS];

   // stage 1
   logic                v1_ff;
   logic [PROD_W-1:0]   s_prod_ff [NUM_DIMS];
   logic [PROD_W-1:0]   d_prod_ff [NUM_DIMS];
   logic [ADDR_W-1:0]   s_base1_ff, d_base1_ff;
   logic                last1_ff, mm1_ff;
   // stage 2
   logic                v2_ff;
   logic [ADDR_W-1:0]   s_sum01_ff, s_sum23_ff, d_sum01_ff, d_sum23_ff;
   logic [ADDR_W-1:0]   s_base2_ff, d_base2_ff;
   logic                last2_ff, mm2_ff;
   // stage 3
   logic                v3_ff;
   logic [ADDR_W-1:0]   s_off_ff, d_off_ff;
   logic [ADDR_W-1:0]   s_base3_ff, d_base3_ff;
   logic                last3_ff, mm3_ff;
   // output
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   // whole pipeline moves together whenever the output slot frees up
   assign en        = !rsp_valid_ff || rsp_ready;
   assign pop       = en && !q_status.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   for (genvar i = 0; i < NUM_DIMS; i++) begin : g_dim
      assign d_idx[i] = q_data[IDX_BASE + i * DIM_BITS +: DIM_BITS];
      assign s_idx[i] = q_data[IDX_BASE + (NUM_DIMS + i) * DIM_BITS +: DIM_BITS];

      always_ff @(posedge clock) begin
         if (en) begin
            s_prod_ff[i] <= s_idx[i] *
                            stride_field(cfg.src_strides_lo, cfg.src_strides_hi, 2'(i));
            d_prod_ff[i] <= d_idx[i] *
                            stride_field(cfg.dst_strides_lo, cfg.dst_strides_hi, 2'(i));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_base1_ff <= q_data[IDX_BASE + 2 * NUM_DIMS * DIM_BITS + ADDR_W +: ADDR_W];
         d_base1_ff <= q_data[IDX_BASE + 2 * NUM_DIMS * DIM_BITS +: ADDR_W];
         last1_ff   <= q_data[1];
         mm1_ff     <= q_data[0];

         s_sum01_ff <= ADDR_W'(s_prod_ff[0]) + ADDR_W'(s_prod_ff[1]);
         s_sum23_ff <= ADDR_W'(s_prod_ff[2]) + ADDR_W'(s_prod_ff[3]);
         d_sum01_ff <= ADDR_W'(d_prod_ff[0]) + ADDR_W'(d_prod_ff[1]);
         d_sum23_ff <= ADDR_W'(d_prod_ff[2]) + ADDR_W'(d_prod_ff[3]);
         s_base2_ff <= s_base1_ff;
         d_base2_ff <= d_base1_ff;
         last2_ff   <= last1_ff;
         mm2_ff     <= mm1_ff;

         s_off_ff   <= s_sum01_ff + s_sum23_ff;
         d_off_ff   <= d_sum01_ff + d_sum23_ff;
         s_base3_ff <= s_base2_ff;
         d_base3_ff <= d_base2_ff;
         last3_ff   <= last2_ff;
         mm3_ff     <= mm2_ff;

         rsp_data_ff.src_address   <= s_base3_ff + (s_off_ff << cfg.elem_size_log2);
         rsp_data_ff.dst_address   <= d_base3_ff + (d_off_ff << cfg.elem_size_log2);
         rsp_data_ff.last          <= last3_ff;
         rsp_data_ff.size_mismatch <= mm3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= !q_status.empty;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

endmodule

/* sv/stc_checker.sv */
// Port-level checks for strided_tensor_copy_addr_gen, attached by bind.
// Depends on stc_pkg for the response type.
module stc_checker import stc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data,
   input logic    csr_we
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock)
      (!reset && rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed or dropped");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // requests held off while the size check settles
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during settle after reset");

   a_ready_after_csr: assert property (@(posedge clock)
      (!reset && csr_we) |=> !req_ready)
      else $error("request accepted right after register write");

endmodule

bind strided_tensor_copy_addr_gen stc_checker u_stc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_we    (csr_we)
);

/* test/tb_top.sv */
// Self-checking testbench for strided_tensor_copy_addr_gen.
// Needs stc_pkg and the block's RTL; predicts every response in place and
// compares field by field while both handshakes idle and stall at random.
`timescale 1ns / 1ps

module tb_top;
   import stc_pkg::*;

   localparam int DIM_BITS = 16;
   localparam logic [63:0] IDX_MASK = (64'd1 << DIM_BITS) - 64'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NONE = 3'd7;   // no register here
   localparam int SIDE_SRC = 0;
   localparam int SIDE_DST = 1;
   localparam int RANDOM_ITEMS = 1300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 16;

   typedef struct packed {
      logic                  is_write;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] wdata;
      req_type               req;
      logic                  pinned;
      rsp_type               pinned_rsp;
   } plan_row;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   cfg_type     cfg_copy;
   logic [63:0] elem_idx [2][4];
   rsp_type     pending_addrs [$];
   plan_row     plan [$];

   bit calm = 1'b0;
   int errors = 0;
   int reqs_sent = 0;
   int copies_done = 0;
   int mismatch_rsps = 0;
   int reg_writes = 0;
   int quiet_cycles = 0;

   strided_tensor_copy_addr_gen #(.DIM_BITS(DIM_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic [63:0] dim_of(input logic [63:0] packed_dims, input int i);
      int unsigned sh;
      sh = i * DIM_BITS;
      if (sh >= 64)
         return 64'd0;
      return (packed_dims >> sh) & IDX_MASK;
   endfunction

   function automatic logic [63:0] stride_of(input logic [63:0] lo, input logic [63:0] hi,
                                             input int i);
      logic [63:0] pair;
      pair = (i >= 2) ? hi : lo;
      return (i % 2 == 1) ? {32'd0, pair[63:32]} : {32'd0, pair[31:0]};
   endfunction

   // bump level 0 and ripple carries up through level 2; top index is returned unmasked
   function automatic logic [63:0] advance_ctr(input int side);
      logic [63:0] dims;
      int i;
      dims = (side == SIDE_SRC) ? cfg_copy.src_shape : cfg_copy.dst_shape;
      elem_idx[side][0] = elem_idx[side][0] + 64'd1;
      for (i = 0; i < 3; i++) begin
         if (elem_idx[side][i] >= dim_of(dims, i)) begin
            elem_idx[side][i] = 64'd0;
            elem_idx[side][i+1] = elem_idx[side][i+1] + 64'd1;
         end
      end
      return elem_idx[side][3];
   endfunction

   function automatic rsp_type next_element(input req_type r);
      logic [63:0] s_tot, d_tot, s_off, d_off, sd, dd;
      logic        any_zero, copy_done;
      int          i, s;
      rsp_type     e;
      s_tot = 64'd1;
      d_tot = 64'd1;
      s_off = 64'd0;
      d_off = 64'd0;
      any_zero = 1'b0;
      for (i = 0; i < 4; i++) begin
         sd = dim_of(cfg_copy.src_shape, i);
         dd = dim_of(cfg_copy.dst_shape, i);
         s_tot = s_tot * sd;
         d_tot = d_tot * dd;
         if (sd == 64'd0 || dd == 64'd0)
            any_zero = 1'b1;
         s_off = s_off + elem_idx[SIDE_SRC][i]
                 * stride_of(cfg_copy.src_strides_lo, cfg_copy.src_strides_hi, i);
         d_off = d_off + elem_idx[SIDE_DST][i]
                 * stride_of(cfg_copy.dst_strides_lo, cfg_copy.dst_strides_hi, i);
      end
      e.src_address = r.src_base + (s_off << cfg_copy.elem_size_log2);
      e.dst_address = r.dst_base + (d_off << cfg_copy.elem_size_log2);

      // source counter alone decides the end of the copy
      copy_done = advance_ctr(SIDE_SRC) >= dim_of(cfg_copy.src_shape, 3);
      if (copy_done) begin
         for (s = 0; s < 2; s++)
            for (i = 0; i < 4; i++)
               elem_idx[s][i] = 64'd0;
      end else begin
         void'(advance_ctr(SIDE_DST));
         for (s = 0; s < 2; s++)
            for (i = 0; i < 4; i++)
               elem_idx[s][i] = elem_idx[s][i] & IDX_MASK;
      end
      e.last = copy_done;
      e.size_mismatch = any_zero || (s_tot != d_tot);
      return e;
   endfunction

   // ---------------------------------------------------------------- random picks

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int pause_cycles();
      int p;
      if (calm)
         return 0;
      p = $urandom_range(0, 99);
      if (p < 60)
         return 0;
      if (p < 88)
         return $urandom_range(1, 3);
      if (p < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [63:0] pick_dims();
      logic [63:0] v;
      int i, p;
      v = '0;
      for (i = 0; i < 4; i++) begin
         p = $urandom_range(0, 99);
         if (p < 78)
            v[i*DIM_BITS +: DIM_BITS] = DIM_BITS'($urandom_range(1, 4));
         else if (p < 90)
            v[i*DIM_BITS +: DIM_BITS] = DIM_BITS'($urandom_range(5, 40));
         else if (p < 95)
            v[i*DIM_BITS +: DIM_BITS] = '0;
         else if (p < 98)
            v[i*DIM_BITS +: DIM_BITS] = '1;
         else
            v[i*DIM_BITS +: DIM_BITS] = DIM_BITS'($urandom);
      end
      return v;
   endfunction

   function automatic logic [63:0] pick_strides();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40)
         return {32'($urandom_range(0, 16)), 32'($urandom_range(0, 16))};
      if (p < 80)
         return rand64();
      if (p < 90)
         return 64'd0;
      return '1;
   endfunction

   function automatic logic [63:0] pick_base();
      int p;
      p = $urandom_range(0, 99);
      if (p < 90)
         return rand64();
      if (p < 95)
         return 64'd0;
      return '1;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_request(input req_type r, input logic pinned, input rsp_type pinned_rsp);
      int gap;
      rsp_type e;
      gap = pause_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      e = next_element(r);
      if (pinned)
         e = pinned_rsp;
      pending_addrs.push_back(e);
      reqs_sent++;
      @(negedge clock);
   endtask

   task automatic send_random_request();
      req_type r;
      r.src_base = pick_base();
      r.dst_base = pick_base();
      send_request(r, 1'b0, '0);
   endtask

   // drop valid, then wait for every outstanding response
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_addrs.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SRC_DIMS:       cfg_copy.src_shape = data;
         CSR_SRC_STRIDES_LO: cfg_copy.src_strides_lo = data;
         CSR_SRC_STRIDES_HI: cfg_copy.src_strides_hi = data;
         CSR_DST_DIMS:       cfg_copy.dst_shape = data;
         CSR_DST_STRIDES_LO: cfg_copy.dst_strides_lo = data;
         CSR_DST_STRIDES_HI: cfg_copy.dst_strides_hi = data;
         CSR_ELEM_SIZE_LOG2: cfg_copy.elem_size_log2 = data[ESZ_W-1:0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
   endtask

   function automatic plan_row w_row(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      plan_row row;
      row = '0;
      row.is_write = 1'b1;
      row.reg_idx = idx;
      row.wdata = data;
      return row;
   endfunction

   // request row; with zero strides the addresses are the bases, so those are pinned
   function automatic plan_row r_row(input logic [63:0] sb, input logic [63:0] db,
                                     input logic pinned, input logic lst, input logic mm);
      plan_row row;
      row = '0;
      row.req.src_base = sb;
      row.req.dst_base = db;
      row.pinned = pinned;
      row.pinned_rsp.src_address = sb;
      row.pinned_rsp.dst_address = db;
      row.pinned_rsp.last = lst;
      row.pinned_rsp.size_mismatch = mm;
      return row;
   endfunction

   // receiver: bursts of ready broken by stalls
   initial begin
      int run, stall;
      @(negedge clock);
      forever begin
         run = $urandom_range(1, 24);
         rsp_ready <= 1'b1;
         repeat (run) @(negedge clock);
         stall = pause_cycles();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- checker

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_addrs.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_data);
            errors++;
         end else begin
            want = pending_addrs.pop_front();
            if (rsp_data.src_address !== want.src_address) begin
               $error("src_address: expected %h, got %h", want.src_address,
                      rsp_data.src_address);
               errors++;
            end
            if (rsp_data.dst_address !== want.dst_address) begin
               $error("dst_address: expected %h, got %h", want.dst_address,
                      rsp_data.dst_address);
               errors++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_data.last);
               errors++;
            end
            if (rsp_data.size_mismatch !== want.size_mismatch) begin
               $error("size_mismatch: expected %b, got %b", want.size_mismatch,
                      rsp_data.size_mismatch);
               errors++;
            end
         end
         if (rsp_data.last === 1'b1)
            copies_done++;
         if (rsp_data.size_mismatch === 1'b1)
            mismatch_rsps++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: %0d cycles without a handshake, %0d responses outstanding",
                  quiet_cycles, pending_addrs.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      int n, k, rand_reqs;
      logic [63:0] sd;
      cfg_copy.src_shape = DIMS_RESET;
      cfg_copy.dst_shape = DIMS_RESET;
      cfg_copy.src_strides_lo = '0;
      cfg_copy.src_strides_hi = '0;
      cfg_copy.dst_strides_lo = '0;
      cfg_copy.dst_strides_hi = '0;
      cfg_copy.elem_size_log2 = '0;
      for (n = 0; n < 2; n++)
         for (k = 0; k < 4; k++)
            elem_idx[n][k] = 64'd0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset shape: every request is a one-element copy at the base addresses
      plan.push_back(r_row(64'd0, 64'd0, 1'b1, 1'b1, 1'b0));
      plan.push_back(r_row('1, '1, 1'b1, 1'b1, 1'b0));
      plan.push_back(r_row(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1, 1'b1, 1'b0));
      // zero source dimensions: always carries, flagged as mismatch
      plan.push_back(w_row(CSR_SRC_DIMS, 64'd0));
      plan.push_back(r_row(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1, 1'b1));
      // totals differ
      plan.push_back(w_row(CSR_SRC_DIMS, DIMS_RESET));
      plan.push_back(w_row(CSR_DST_DIMS, 64'h0001_0001_0001_0002));
      plan.push_back(r_row(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b1, 1'b1, 1'b1));
      // zero destination top dimension
      plan.push_back(w_row(CSR_DST_DIMS, 64'h0000_0001_0001_0001));
      plan.push_back(r_row(64'h8000_0000_0000_0001, 64'h0000_0000_0000_0080, 1'b1, 1'b1, 1'b1));
      // largest shapes and strides, element size log2 of 6; addresses wrap
      plan.push_back(w_row(CSR_SRC_DIMS, '1));
      plan.push_back(w_row(CSR_DST_DIMS, '1));
      plan.push_back(w_row(CSR_SRC_STRIDES_LO, '1));
      plan.push_back(w_row(CSR_SRC_STRIDES_HI, '1));
      plan.push_back(w_row(CSR_DST_STRIDES_LO, '1));
      plan.push_back(w_row(CSR_DST_STRIDES_HI, '1));
      plan.push_back(w_row(CSR_ELEM_SIZE_LOG2, 64'd6));
      for (k = 0; k < 4; k++)
         plan.push_back(r_row('1, 64'hFFFF_FFFF_FFFF_FF00, 1'b0, 1'b0, 1'b0));
      // shrink mid-copy: level 0 index is now past its size and wraps at once
      plan.push_back(w_row(CSR_SRC_DIMS, 64'h0002_0001_0002_0002));
      plan.push_back(w_row(CSR_DST_DIMS, 64'h0001_0002_0001_0004));
      plan.push_back(w_row(CSR_SRC_STRIDES_LO, 64'h0000_0010_0000_0001));
      plan.push_back(w_row(CSR_SRC_STRIDES_HI, 64'h0000_0100_0000_0040));
      plan.push_back(w_row(CSR_DST_STRIDES_LO, 64'h0000_0004_0000_0001));
      plan.push_back(w_row(CSR_DST_STRIDES_HI, 64'h8000_0000_0000_0008));
      plan.push_back(w_row(CSR_NONE, '1));
      // bits above the register width are dropped
      plan.push_back(w_row(CSR_ELEM_SIZE_LOG2, 64'hFFFF_FFFF_FFFF_FFFD));
      for (k = 0; k < 9; k++)
         plan.push_back(r_row(64'h0000_1000_0000_0000 + k, 64'h0000_2000_0000_0000, 1'b0,
                              1'b0, 1'b0));

      foreach (plan[k]) begin
         if (plan[k].is_write) begin
            wait_idle();
            write_reg(plan[k].reg_idx, plan[k].wdata);
         end else begin
            send_request(plan[k].req, plan[k].pinned, plan[k].pinned_rsp);
         end
      end

      // random phases; counters carry over between them
      rand_reqs = 0;
      while (rand_reqs < RANDOM_ITEMS) begin
         wait_idle();
         calm = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) < 8) begin
            sd = pick_dims();
            write_reg(CSR_SRC_DIMS, sd);
            if ($urandom_range(0, 1) == 0) begin
               // rotated copy of the source shape: equal totals
               n = $urandom_range(0, 3);
               sd = 64'({cfg_copy.src_shape, cfg_copy.src_shape} >> (n * DIM_BITS));
            end else begin
               sd = pick_dims();
            end
            write_reg(CSR_DST_DIMS, sd);
         end
         if ($urandom_range(0, 9) < 6) begin
            write_reg(CSR_SRC_STRIDES_LO, pick_strides());
            write_reg(CSR_SRC_STRIDES_HI, pick_strides());
         end
         if ($urandom_range(0, 9) < 6) begin
            write_reg(CSR_DST_STRIDES_LO, pick_strides());
            write_reg(CSR_DST_STRIDES_HI, pick_strides());
         end
         if ($urandom_range(0, 9) < 5)
            write_reg(CSR_ELEM_SIZE_LOG2,
                      {61'(rand64() >> ESZ_W), 3'($urandom_range(0, 6))});
         if ($urandom_range(0, 9) == 0)
            write_reg(CSR_NONE, rand64());
         n = $urandom_range(10, 60);
         for (k = 0; k < n; k++)
            send_random_request();
         rand_reqs += n;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests over %0d register writes; %0d copies finished, %0d flagged",
               reqs_sent, reg_writes, copies_done, mismatch_rsps);
      $display("%0d errors, %0d responses outstanding", errors, pending_addrs.size());
      if (errors == 0 && pending_addrs.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
